@@ rtl/pfla_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page free list allocator package
// Shared request and response types, operation and status codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfla_pkg;

  localparam int unsigned PAGE_W = 12;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TOUCH = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page;
  } pfla_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_out;
    logic [STAT_W-1:0] status;
  } pfla_rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_POP,
    S_GROW
  } pfla_state_e;

  typedef struct packed {
    logic              capture;
    logic              clr_step;
    logic              pop_fin;
    logic              free_wr;
    logic              grow_alloc;
    logic              grow_touch;
    logic              rsp_en;
    logic [STAT_W-1:0] rsp_status;
  } pfla_cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic            head_zero;
    logic            can_grow;
    logic            covered;
    logic            page_ok;
    logic [OP_W-1:0] op;
  } pfla_sts_t;

endpackage

@@ rtl/pfla_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page free list allocator controller
// Sequences the link memory clear after reset and each request through
// decode, link pop or repeated pool doubling, and raises the response.
// ----------------------------------------------------------------------------
module pfla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  pfla_pkg::pfla_sts_t sts_i,
  output logic               busy_o,
  output pfla_pkg::pfla_cmd_t cmd_o
);
  import pfla_pkg::*;

  pfla_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.op == OP_ALLOC && !sts_i.head_zero) begin
          state_d = S_POP;
        end else if (sts_i.op == OP_TOUCH) begin
          state_d = S_GROW;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        state_d = S_IDLE;
      end
      S_GROW: begin
        if (sts_i.covered || !sts_i.can_grow) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      S_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      S_EXEC: begin
        priority if (sts_i.op == OP_ALLOC) begin
          if (sts_i.head_zero) begin
            cmd_o.rsp_en = 1'b1;
            if (sts_i.can_grow) begin
              cmd_o.grow_alloc = 1'b1;
              cmd_o.rsp_status = STATUS_OK;
            end else begin
              cmd_o.rsp_status = STATUS_FULL;
            end
          end
        end else if (sts_i.op == OP_FREE) begin
          cmd_o.rsp_en = 1'b1;
          if (sts_i.page_ok) begin
            cmd_o.free_wr    = 1'b1;
            cmd_o.rsp_status = STATUS_OK;
          end else begin
            cmd_o.rsp_status = STATUS_INVALID;
          end
        end else if (sts_i.op == OP_TOUCH) begin
          cmd_o.rsp_en = 1'b0;
        end else begin
          cmd_o.rsp_en     = 1'b1;
          cmd_o.rsp_status = STATUS_OK;
        end
      end
      S_POP: begin
        cmd_o.pop_fin    = 1'b1;
        cmd_o.rsp_en     = 1'b1;
        cmd_o.rsp_status = STATUS_OK;
      end
      S_GROW: begin
        priority if (sts_i.covered) begin
          cmd_o.rsp_en     = 1'b1;
          cmd_o.rsp_status = STATUS_OK;
        end else if (!sts_i.can_grow) begin
          cmd_o.rsp_en     = 1'b1;
          cmd_o.rsp_status = STATUS_FULL;
        end else begin
          cmd_o.grow_touch = 1'b1;
        end
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/pfla_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page free list allocator datapath
// Holds the link memory, the free list head and the page count, and builds
// the response from the commands of the controller.
// ----------------------------------------------------------------------------
module pfla_dp #(
  parameter int unsigned MAX_PAGES     = 4096,
  parameter int unsigned INITIAL_PAGES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfla_pkg::pfla_req_t req_i,
  input  pfla_pkg::pfla_cmd_t cmd_i,
  output pfla_pkg::pfla_sts_t sts_o,
  output logic                done_o,
  output pfla_pkg::pfla_rsp_t rsp_o
);
  import pfla_pkg::*;

  localparam int unsigned PW   = $clog2(MAX_PAGES);
  localparam int unsigned CW   = PW + 1;
  localparam int unsigned CMPW = (CW > PAGE_W) ? CW : PAGE_W;

  logic [PW-1:0] link_mem [MAX_PAGES];
  logic [PW-1:0] rdata_q;

  pfla_req_t     req_q;
  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] clr_q;
  logic          done_q;
  pfla_rsp_t     rsp_q, rsp_d;

  logic          mem_we;
  logic [PW-1:0] mem_wa;
  logic [PW-1:0] mem_wd;
  logic [CW-1:0] count_dbl;
  logic [CW:0]   count_dbl_ext;

  assign count_dbl     = count_q << 1;
  assign count_dbl_ext = {1'b0, count_q} << 1;

  assign sts_o.clr_last  = (clr_q == PW'(MAX_PAGES - 1));
  assign sts_o.head_zero = (head_q == '0);
  assign sts_o.can_grow  = (count_q != '0) && (count_dbl_ext <= (CW + 1)'(MAX_PAGES));
  assign sts_o.covered   = (CMPW'(req_q.page) < CMPW'(count_q));
  assign sts_o.page_ok   = (req_q.page != '0) && sts_o.covered;
  assign sts_o.op        = req_q.op;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_q;
    mem_wd = (clr_q == '0) ? '0 : clr_q - PW'(1);
    priority if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.free_wr) begin
      mem_we = 1'b1;
      mem_wa = PW'(req_q.page);
      mem_wd = head_q;
    end else if (cmd_i.grow_alloc || cmd_i.grow_touch) begin
      mem_we = 1'b1;
      mem_wa = PW'(count_q);
      mem_wd = head_q;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    rdata_q <= link_mem[head_q];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    priority if (cmd_i.pop_fin) begin
      head_d = rdata_q;
    end else if (cmd_i.free_wr) begin
      head_d = PW'(req_q.page);
    end else if (cmd_i.grow_alloc) begin
      head_d  = PW'(count_dbl - CW'(2));
      count_d = count_dbl;
    end else if (cmd_i.grow_touch) begin
      head_d  = PW'(count_dbl - CW'(1));
      count_d = count_dbl;
    end else begin
      head_d = head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= PW'(INITIAL_PAGES - 1);
      count_q <= CW'(INITIAL_PAGES);
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= cmd_i.rsp_en;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + PW'(1);
      end
    end
  end

  always_comb begin
    rsp_d.status = cmd_i.rsp_status;
    priority if (cmd_i.grow_alloc) begin
      rsp_d.page_out = PAGE_W'(count_dbl - CW'(1));
    end else if (cmd_i.pop_fin) begin
      rsp_d.page_out = PAGE_W'(head_q);
    end else begin
      rsp_d.page_out = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.rsp_en) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ rtl/page_free_list_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page free list allocator
// Hands out, takes back and extends a pool of page numbers kept as a linked
// free list, growing the pool by doubling when it runs dry.
// ----------------------------------------------------------------------------
// After reset the block sweeps the link memory, one entry per cycle, so busy_o
// stays high until every entry has been written, and no request is taken before
// then. A request is taken when start_i is high and busy_o is low; its response
// appears on rsp_o with done_o high for exactly one cycle and must be taken
// then. A free, an allocate from an empty list or an unused operation is
// answered from the decode state; an allocate that pops the list waits in a
// further state for the registered link memory read, and a touch doubles the
// pool once per grow step until the page is covered or the pool cannot double
// again. A new request may be started in the cycle in which the previous response is shown.
// ----------------------------------------------------------------------------
module page_free_list_allocator #(
  parameter int unsigned MAX_PAGES     = 4096,
  parameter int unsigned INITIAL_PAGES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pfla_pkg::pfla_req_t req_i,
  output logic                busy_o,
  output logic                done_o,
  output pfla_pkg::pfla_rsp_t rsp_o
);
  import pfla_pkg::*;

  pfla_cmd_t cmd;
  pfla_sts_t sts;

  pfla_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  pfla_dp #(
    .MAX_PAGES     (MAX_PAGES),
    .INITIAL_PAGES (INITIAL_PAGES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule
